[design/tsoa_pkg.sv]
`timescale 1ns / 1ps

package tsoa_pkg;

   // Store geometry
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = CNT_W + 1;
   localparam int DATA_W   = 32;

   localparam logic [CNT_W-1:0] BASE_RESET = CNT_W'(CAPACITY / 3);

   // Request kinds (any other kind behaves as a peek)
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;

   // Stack identifiers
   localparam logic [1:0] STACK_LOW  = 2'd0;
   localparam logic [1:0] STACK_MID  = 2'd1;
   localparam logic [1:0] STACK_HIGH = 2'd2;
   localparam logic [1:0] STACK_BAD  = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BAD_ID = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [1:0]               stack_id;
      logic signed [DATA_W-1:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [1:0]               status;
   } rsp_item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_cmd_type;

   // Clamp a position onto the last entry of the store
   function automatic logic [ADDR_W-1:0] slot(input logic [POS_W-1:0] pos);
      if (pos < POS_W'(CAPACITY)) begin
         return pos[ADDR_W-1:0];
      end
      return ADDR_W'(CAPACITY - 1);
   endfunction

endpackage

[design/three_stacks_one_array.sv]
`timescale 1ns / 1ps

// Three LIFO stacks sharing one 32-bit store of CAPACITY entries.
// Stack 0 grows up from entry 0, stack 1 up from a movable base, stack 2
// down from the last entry.
// req_*: one transaction is a push, pop or peek on one stack (valid/ready).
// rsp_*: exactly one result per request, value and status (valid/ready),
// in request order.
// Requests are handled one at a time: a new request is taken only once the
// controller is back in idle. Pops, peeks and pushes that need no slide go
// through EXEC, then READ_WAIT or PUSH_WR, then DONE; errors (bad id, full
// store, empty stack) go from EXEC straight to DONE. A push that slides the
// middle stack first moves each of its entries: each entry is read and then
// written back through the store, one entry at a time.
// Reset clears the three counts and puts the middle base at CAPACITY/3.
// The store contents are left as they are and need no clearing pass.
// When the receiver stalls, the result waits in the output register; the
// next request is still accepted and worked on, and its result waits in the
// controller until the output register frees up.
module three_stacks_one_array (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tsoa_pkg::req_item_type   req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tsoa_pkg::rsp_item_type   rsp_data
);
   import tsoa_pkg::*;

   logic              res_valid;
   logic              res_ready;
   rsp_item_type      res_data;
   ram_cmd_type       ram_cmd;
   logic [DATA_W-1:0] ram_rd_data;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   tsoa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   tsoa_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

   // Load the output register when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // One request at a time: acceptance closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction was in progress");

   // A finished result reaches the output on the next cycle
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_valid)
      else $error("finished result lost before the output register");

   // Error results carry a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.value == '0)
      else $error("error result with a non-zero value");
`endif

endmodule

[design/tsoa_ram.sv]
`timescale 1ns / 1ps

module tsoa_ram (
   input  logic                          clock,
   input  tsoa_pkg::ram_cmd_type         cmd,
   output logic [tsoa_pkg::DATA_W-1:0]   rd_data
);
   import tsoa_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tsoa_ctrl.sv]
`timescale 1ns / 1ps

module tsoa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tsoa_pkg::req_item_type        req_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output tsoa_pkg::rsp_item_type        res_data,
   output tsoa_pkg::ram_cmd_type         ram_cmd,
   input  logic [tsoa_pkg::DATA_W-1:0]   ram_rd_data
);
   import tsoa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SLIDE_RD,
      S_SLIDE_WR,
      S_PUSH_WR,
      S_READ_WAIT,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   req_item_type             req_ff, req_in;
   logic [CNT_W-1:0]         cnt_ff [3];
   logic [CNT_W-1:0]         cnt_in [3];
   logic [CNT_W-1:0]         base_ff, base_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     fwd_ff, fwd_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [1:0]               status_ff, status_in;

   logic [CNT_W-1:0] cur_cnt;
   logic [CNT_W+1:0] total;
   logic [CNT_W+1:0] mid_end;
   logic [POS_W-1:0] top_pos;
   logic [POS_W-1:0] push_pos;
   logic [POS_W-1:0] rd_pos;
   logic [POS_W-1:0] wr_pos;
   logic             slide_done;

   // Select the count of the addressed stack
   always_comb begin
      case (req_ff.stack_id)
         STACK_LOW: cur_cnt = cnt_ff[0];
         STACK_MID: cur_cnt = cnt_ff[1];
         default:   cur_cnt = cnt_ff[2];
      endcase
   end

   // Fill levels and positions of the tops
   assign total   = (CNT_W+2)'(cnt_ff[0]) + (CNT_W+2)'(cnt_ff[1]) + (CNT_W+2)'(cnt_ff[2]);
   assign mid_end = (CNT_W+2)'(base_ff) + (CNT_W+2)'(cnt_ff[1]) + (CNT_W+2)'(cnt_ff[2]);

   always_comb begin
      case (req_ff.stack_id)
         STACK_LOW: begin
            top_pos  = POS_W'(cnt_ff[0]) - POS_W'(1);
            push_pos = POS_W'(cnt_ff[0]);
         end
         STACK_MID: begin
            top_pos  = POS_W'(base_ff) + POS_W'(cnt_ff[1]) - POS_W'(1);
            push_pos = POS_W'(base_ff) + POS_W'(cnt_ff[1]);
         end
         default: begin
            top_pos  = POS_W'(CAPACITY) - POS_W'(cnt_ff[2]);
            push_pos = POS_W'(CAPACITY) - POS_W'(cnt_ff[2]) - POS_W'(1);
         end
      endcase
   end

   // Source and target of one slide move
   always_comb begin
      if (fwd_ff) begin
         rd_pos     = POS_W'(base_ff) + POS_W'(idx_ff) - POS_W'(1);
         wr_pos     = POS_W'(base_ff) + POS_W'(idx_ff);
         slide_done = (idx_ff == '0);
      end else begin
         rd_pos     = POS_W'(base_ff) + POS_W'(idx_ff);
         wr_pos     = POS_W'(base_ff) + POS_W'(idx_ff) - POS_W'(1);
         slide_done = (idx_ff == cnt_ff[1]);
      end
   end

   // Sequence one transaction through the store
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      cnt_in    = cnt_ff;
      base_in   = base_ff;
      idx_in    = idx_ff;
      fwd_in    = fwd_ff;
      value_in  = value_ff;
      status_in = status_ff;
      ram_cmd   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            value_in  = '0;
            status_in = ST_OK;
            if (req_ff.stack_id == STACK_BAD) begin
               status_in = ST_BAD_ID;
               state_in  = S_DONE;
            end else if (req_ff.req_type == REQ_PUSH) begin
               if (total >= (CNT_W+2)'(CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else if (req_ff.stack_id == STACK_LOW && cnt_ff[0] == base_ff) begin
                  fwd_in   = 1'b1;
                  idx_in   = cnt_ff[1];
                  state_in = S_SLIDE_RD;
               end else if (req_ff.stack_id != STACK_LOW &&
                            mid_end == (CNT_W+2)'(CAPACITY) && base_ff != '0) begin
                  fwd_in   = 1'b0;
                  idx_in   = '0;
                  state_in = S_SLIDE_RD;
               end else begin
                  state_in = S_PUSH_WR;
               end
            end else if (cur_cnt == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_DONE;
            end else begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = slot(top_pos);
               state_in        = S_READ_WAIT;
            end
         end
         S_SLIDE_RD: begin
            if (slide_done) begin
               if (fwd_ff) begin
                  if (base_ff < CNT_W'(CAPACITY)) begin
                     base_in = base_ff + CNT_W'(1);
                  end
               end else begin
                  base_in = base_ff - CNT_W'(1);
               end
               state_in = S_PUSH_WR;
            end else begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = slot(rd_pos);
               state_in        = S_SLIDE_WR;
            end
         end
         S_SLIDE_WR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = slot(wr_pos);
            ram_cmd.wr_data = ram_rd_data;
            idx_in          = fwd_ff ? idx_ff - CNT_W'(1) : idx_ff + CNT_W'(1);
            state_in        = S_SLIDE_RD;
         end
         S_PUSH_WR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = slot(push_pos);
            ram_cmd.wr_data = req_ff.push_value;
            for (int k = 0; k < 3; k++) begin
               if (req_ff.stack_id == 2'(k)) begin
                  cnt_in[k] = cnt_ff[k] + CNT_W'(1);
               end
            end
            state_in = S_DONE;
         end
         S_READ_WAIT: begin
            value_in = $signed(ram_rd_data);
            if (req_ff.req_type == REQ_POP) begin
               for (int k = 0; k < 3; k++) begin
                  if (req_ff.stack_id == 2'(k)) begin
                     cnt_in[k] = cnt_ff[k] - CNT_W'(1);
                  end
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, request, counts, middle base, slide index and the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '{default: '0};
         base_ff  <= BASE_RESET;
         idx_ff   <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         base_ff  <= base_in;
         idx_ff   <= idx_in;
         fwd_ff   <= fwd_in;
      end
      req_ff    <= req_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_DONE);
   assign res_data.value  = value_ff;
   assign res_data.status = status_ff;

endmodule
